>>> src/trle_pkg.sv
// Package for the tagged run-length byte encoder: command codes, result slot
// codes, the job record passed from front to back, and fixed sizes.
// No dependencies.
`timescale 1ns / 1ps

package trle_pkg;

    // Command codes carried on the input tuser
    typedef enum logic [1:0] {
        CMD_COUNT  = 2'd0,
        CMD_ENCODE = 2'd1,
        CMD_EMPTY  = 2'd2
    } cmd_t;

    // Tag search state
    typedef enum logic [1:0] {
        PICK_IDLE,
        PICK_GROUP,
        PICK_FINAL
    } pick_state_t;

    // Byte value space, split into groups for the two-step tag search
    localparam int VALUES  = 256;
    localparam int GROUP_W = 16;
    localparam int GROUP_N = VALUES / GROUP_W;
    localparam int GIDX_W  = $clog2(GROUP_W);
    localparam int GSEL_W  = $clog2(GROUP_N);

    localparam logic [7:0] RUN_CAP = 8'd255;
    localparam logic [7:0] RUN_ONE = 8'd1;
    localparam logic [7:0] RUN_TWO = 8'd2;

    // Result slots of one job, emitted from the lowest set bit upward
    localparam int SLOT_HEAD     = 0;  // tag opening the stream
    localparam int SLOT_PREV     = 1;  // second literal of a run of two
    localparam int SLOT_RUN_TAG  = 2;  // tag before a repeat count
    localparam int SLOT_RUN_CNT  = 3;  // repeat count
    localparam int SLOT_LIT      = 4;  // literal of the new run
    localparam int SLOT_END_TAG  = 5;  // tag closing the stream
    localparam int SLOT_END_ZERO = 6;  // zero closing the stream, last
    localparam int SLOT_STATUS   = 7;  // no-tag status, last
    localparam int SLOT_N        = 8;

    typedef logic [SLOT_N-1:0] slot_mask_t;

    typedef struct packed {
        slot_mask_t mask;
        logic [7:0] tag;
        logic [7:0] lit;
        logic [7:0] prev;
        logic [7:0] cnt;
    } job_t;

endpackage

>>> src/trle_front.sv
// Front end of the tagged RLE encoder: accepts input transactions, keeps the
// seen-value map, tag search and run state, and issues a job for each item that has results.
// Depends on trle_pkg.
`timescale 1ns / 1ps

module trle_front
    import trle_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic [1:0] s_tuser,   // [1:0] cmd
    input  logic       s_tlast,
    input  logic       q_full,
    output logic       q_push,
    output job_t       q_job
);

    // Lowest clear bit position in a 16-bit word
    function automatic logic [GIDX_W-1:0] first_clear(input logic [GROUP_W-1:0] v);
        logic [GIDX_W-1:0] idx;
        idx = '0;
        for (int i = GROUP_W - 1; i >= 0; i--)
        begin
            if (!v[i])
            begin
                idx = GIDX_W'(i);
            end
        end
        return idx;
    endfunction

    logic [VALUES-1:0]  seen_reg, seen_next;
    logic [7:0]         tag_reg, tag_next;
    logic               missing_reg, missing_next;
    logic [7:0]         prev_reg, prev_next;
    logic [7:0]         run_reg, run_next;
    logic               started_reg, started_next;
    pick_state_t        pick_state_reg, pick_state_next;

    logic [GROUP_N-1:0] grp_free_reg, grp_free_next;
    logic [GIDX_W-1:0]  grp_idx_reg  [GROUP_N];
    logic [GIDX_W-1:0]  grp_idx_next [GROUP_N];

    logic               accept;
    cmd_t               cmd;
    logic [GSEL_W-1:0]  final_grp;
    logic               clear;
    job_t               job;

    assign accept   = s_tvalid && s_tready;
    assign cmd      = cmd_t'(s_tuser);
    assign s_tready = (pick_state_reg == PICK_IDLE) && !q_full;
    assign q_push   = accept && (job.mask != '0);
    assign q_job    = job;

    // Tag search, step one: lowest free value within each group
    always_comb
    begin
        for (int g = 0; g < GROUP_N; g++)
        begin
            grp_free_next[g] = ~&seen_reg[g*GROUP_W +: GROUP_W];
            grp_idx_next[g]  = first_clear(seen_reg[g*GROUP_W +: GROUP_W]);
        end
    end

    // Tag search, step two: lowest group that has a free value
    assign final_grp = first_clear(~grp_free_reg);

    // Tag search sequencing
    always_comb
    begin
        pick_state_next = pick_state_reg;
        case (pick_state_reg)
            PICK_IDLE:
            begin
                if (accept && (cmd == CMD_COUNT) && s_tlast)
                begin
                    pick_state_next = PICK_GROUP;
                end
            end
            PICK_GROUP: pick_state_next = PICK_FINAL;
            PICK_FINAL: pick_state_next = PICK_IDLE;
            default:    pick_state_next = PICK_IDLE;
        endcase
    end

    // Classify the accepted transaction, build its job, advance run state
    always_comb
    begin
        seen_next    = seen_reg;
        tag_next     = tag_reg;
        missing_next = missing_reg;
        prev_next    = prev_reg;
        run_next     = run_reg;
        started_next = started_reg;
        clear        = 1'b0;
        job.mask     = '0;
        job.tag      = tag_reg;
        job.lit      = s_tdata;
        job.prev     = prev_reg;
        job.cnt      = run_reg - RUN_ONE;

        if (pick_state_reg == PICK_FINAL)
        begin
            tag_next     = {final_grp, grp_idx_reg[final_grp]};
            missing_next = (grp_free_reg == '0);
        end

        if (accept)
        begin
            case (cmd)
                CMD_COUNT:
                begin
                    seen_next[s_tdata] = 1'b1;
                end
                CMD_ENCODE:
                begin
                    if (missing_reg)
                    begin
                        if (s_tlast)
                        begin
                            job.mask[SLOT_STATUS] = 1'b1;
                            clear = 1'b1;
                        end
                    end
                    else
                    begin
                        if (!started_reg)
                        begin
                            job.mask[SLOT_HEAD] = 1'b1;
                            job.mask[SLOT_LIT]  = 1'b1;
                            prev_next    = s_tdata;
                            run_next     = RUN_ONE;
                            started_next = 1'b1;
                        end
                        else if ((s_tdata != prev_reg) || (run_reg == RUN_CAP) || s_tlast)
                        begin
                            if (run_reg == RUN_TWO)
                            begin
                                job.mask[SLOT_PREV] = 1'b1;
                            end
                            else if (run_reg > RUN_TWO)
                            begin
                                job.mask[SLOT_RUN_TAG] = 1'b1;
                                job.mask[SLOT_RUN_CNT] = 1'b1;
                            end
                            job.mask[SLOT_LIT] = 1'b1;
                            prev_next = s_tdata;
                            run_next  = RUN_ONE;
                        end
                        else
                        begin
                            run_next = run_reg + RUN_ONE;
                        end

                        if (s_tlast)
                        begin
                            job.mask[SLOT_END_TAG]  = 1'b1;
                            job.mask[SLOT_END_ZERO] = 1'b1;
                            clear = 1'b1;
                        end
                    end
                end
                CMD_EMPTY:
                begin
                    job.mask[SLOT_HEAD]     = 1'b1;
                    job.mask[SLOT_END_TAG]  = 1'b1;
                    job.mask[SLOT_END_ZERO] = 1'b1;
                    job.tag = 8'd0;
                    clear   = 1'b1;
                end
                default: ;
            endcase
        end

        // Return block state to reset values at the end of a block
        if (clear)
        begin
            seen_next    = '0;
            tag_next     = 8'd0;
            missing_next = 1'b0;
            prev_next    = 8'd0;
            run_next     = RUN_ONE;
            started_next = 1'b0;
        end
    end

    // Block state and tag search registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg       <= '0;
            tag_reg        <= 8'd0;
            missing_reg    <= 1'b0;
            prev_reg       <= 8'd0;
            run_reg        <= RUN_ONE;
            started_reg    <= 1'b0;
            pick_state_reg <= PICK_IDLE;
        end
        else
        begin
            seen_reg       <= seen_next;
            tag_reg        <= tag_next;
            missing_reg    <= missing_next;
            prev_reg       <= prev_next;
            run_reg        <= run_next;
            started_reg    <= started_next;
            pick_state_reg <= pick_state_next;
        end
    end

    // Group results of the tag search
    always_ff @(posedge clk)
    begin
        if (pick_state_reg == PICK_GROUP)
        begin
            grp_free_reg <= grp_free_next;
            grp_idx_reg  <= grp_idx_next;
        end
    end

`ifndef SYNTHESIS
    // Encode-pass end returns the run state to its start
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (cmd == CMD_ENCODE) && s_tlast) |=> (!started_reg && (run_reg == RUN_ONE)))
    else $error("run state not cleared after block end");

    // A finished count pass leads to a tag search with input held off
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (cmd == CMD_COUNT) && s_tlast) |=> (pick_state_reg == PICK_GROUP) ##1
        (pick_state_reg == PICK_FINAL))
    else $error("tag search not sequenced after count pass");
`endif

endmodule

>>> src/trle_fifo.sv
// Job queue between the front and back ends of the tagged RLE encoder.
// Depends on trle_pkg.
`timescale 1ns / 1ps

module trle_fifo
    import trle_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_data,
    output logic full,
    input  logic pop,
    output logic pop_valid,
    output job_t pop_data
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    job_t          mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign full      = (count_reg == CW'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data  = mem[rd_ptr_reg];

    // Store pushed jobs
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    // No job written into a full queue
    assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("job queue overflow");

    // No job taken from an empty queue
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> pop_valid)
    else $error("job queue underflow");
`endif

endmodule

>>> src/trle_back.sv
// Back end of the tagged RLE encoder: expands queued jobs into result
// transactions, one byte per cycle while m_tready does not stall it, through an output register.
// Depends on trle_pkg.
`timescale 1ns / 1ps

module trle_back
    import trle_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    input  job_t       q_job,
    output logic       q_pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [0:0] m_tuser,   // [0] out_status
    output logic       m_tlast
);

    slot_mask_t cur_mask_reg;
    job_t       cur_job_reg;
    logic       m_valid_reg;
    logic [7:0] m_data_reg;
    logic       m_status_reg;
    logic       m_last_reg;

    logic       adv;
    logic       emit;
    slot_mask_t mask_after;
    logic [7:0] sel_byte;
    logic       sel_last;
    logic       sel_status;

    assign adv        = !m_valid_reg || m_tready;
    assign emit       = adv && (cur_mask_reg != '0);
    assign mask_after = emit ? (cur_mask_reg & (cur_mask_reg - 1'b1)) : cur_mask_reg;
    assign q_pop      = q_valid && (mask_after == '0);

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser    = m_status_reg;
    assign m_tlast    = m_last_reg;

    // Pick the result of the lowest pending slot
    always_comb
    begin
        sel_byte   = 8'd0;
        sel_last   = 1'b0;
        sel_status = 1'b0;
        if (cur_mask_reg[SLOT_HEAD])
        begin
            sel_byte = cur_job_reg.tag;
        end
        else if (cur_mask_reg[SLOT_PREV])
        begin
            sel_byte = cur_job_reg.prev;
        end
        else if (cur_mask_reg[SLOT_RUN_TAG])
        begin
            sel_byte = cur_job_reg.tag;
        end
        else if (cur_mask_reg[SLOT_RUN_CNT])
        begin
            sel_byte = cur_job_reg.cnt;
        end
        else if (cur_mask_reg[SLOT_LIT])
        begin
            sel_byte = cur_job_reg.lit;
        end
        else if (cur_mask_reg[SLOT_END_TAG])
        begin
            sel_byte = cur_job_reg.tag;
        end
        else if (cur_mask_reg[SLOT_END_ZERO])
        begin
            sel_last = 1'b1;
        end
        else
        begin
            sel_last   = 1'b1;
            sel_status = 1'b1;
        end
    end

    // Track pending slots and load the next job
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_mask_reg <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            cur_mask_reg <= q_pop ? q_job.mask : mask_after;
            if (adv)
            begin
                m_valid_reg <= emit;
            end
        end
    end

    // Job payload and output register payload
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_job_reg <= q_job;
        end
        if (emit)
        begin
            m_data_reg   <= sel_byte;
            m_last_reg   <= sel_last;
            m_status_reg <= sel_status;
        end
    end

`ifndef SYNTHESIS
    // A no-tag status always closes the block
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tlast && (m_tdata == 8'd0)))
    else $error("status result not final");
`endif

endmodule

>>> src/tagged_rle_byte_encoder_core.sv
// Result path: an item's job passes the job queue, the pending-slot register and the output
// register before m_tvalid of its first result rises.
// Throughput: one input transaction per cycle, one result per cycle while m_tready is high;
// after a count pass ends, the two-step tag search holds s_tready low, as does a full
// job queue of QUEUE_DEPTH entries, which absorbs result bursts.
// Reset: rst_n clears the value map, tag, run state, queue and output register.
`timescale 1ns / 1ps

module tagged_rle_byte_encoder_core
    import trle_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic [1:0] s_tuser,   // [1:0] cmd
    input  logic       s_tlast,   // in_last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [0:0] m_tuser,   // [0] out_status
    output logic       m_tlast    // out_last
);

    logic q_full;
    logic q_push;
    job_t q_push_job;
    logic q_pop;
    logic q_valid;
    job_t q_pop_job;

    // Classify transactions and issue jobs
    trle_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_job    (q_push_job)
    );

    // Buffer jobs between front and back
    trle_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_job),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_data  (q_pop_job)
    );

    // Expand jobs into result transactions
    trle_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_job    (q_pop_job),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

>>> tb/trle_stream_checker.sv
// Stream checker for the tagged run-length byte encoder: watches both channels,
// predicts the encoded stream and compares every result transaction.
// Depends on trle_pkg for command codes and run length constants.
`timescale 1ns / 1ps

module trle_stream_checker
    import trle_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic [1:0] s_tuser,   // [1:0] cmd
    input  logic       s_tlast,   // in_last
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,   // [7:0] out_byte
    input  logic [0:0] m_tuser,   // [0] out_status
    input  logic       m_tlast,   // out_last
    output int         fail_count,
    output int         pending
);

    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       status;
    } enc_byte_t;

    enc_byte_t         enc_bytes_q[$];

    // Predicted block state
    logic [VALUES-1:0] value_seen;
    logic [7:0]        esc_tag;
    logic              no_tag;
    logic [7:0]        run_byte;
    logic [7:0]        run_len;
    logic              stream_open;

    function automatic void reset_block();
        value_seen  = '0;
        esc_tag     = 8'd0;
        no_tag      = 1'b0;
        run_byte    = 8'd0;
        run_len     = RUN_ONE;
        stream_open = 1'b0;
    endfunction

    function automatic void emit(input logic [7:0] data, input logic last,
                                 input logic status);
        enc_byte_t e;
        e.data   = data;
        e.last   = last;
        e.status = status;
        enc_bytes_q.insert(enc_bytes_q.size(), e);
    endfunction

    // Lowest value never marked becomes the escape tag
    function automatic void choose_tag();
        no_tag  = 1'b1;
        esc_tag = 8'd0;
        for (int v = 0; v < VALUES; v++)
        begin
            if (no_tag && !value_seen[v])
            begin
                esc_tag = v[7:0];
                no_tag  = 1'b0;
            end
        end
    endfunction

    function automatic void encode_step(input logic [1:0] cmd, input logic [7:0] data,
                                        input logic last);
        case (cmd)
            CMD_COUNT:
            begin
                value_seen[data] = 1'b1;
                if (last)
                    choose_tag();
            end
            CMD_EMPTY:
            begin
                reset_block();
                emit(8'd0, 1'b0, 1'b0);
                emit(8'd0, 1'b0, 1'b0);
                emit(8'd0, 1'b1, 1'b0);
            end
            CMD_ENCODE:
            begin
                if (no_tag)
                begin
                    // Only a status transaction closes a block without a tag
                    if (last)
                    begin
                        emit(8'd0, 1'b1, 1'b1);
                        reset_block();
                    end
                end
                else
                begin
                    if (!stream_open)
                    begin
                        emit(esc_tag, 1'b0, 1'b0);
                        emit(data, 1'b0, 1'b0);
                        run_byte    = data;
                        run_len     = RUN_ONE;
                        stream_open = 1'b1;
                    end
                    else if (data != run_byte || run_len >= RUN_CAP || last)
                    begin
                        // Flush the current run, then start a new one
                        if (run_len == RUN_TWO)
                            emit(run_byte, 1'b0, 1'b0);
                        else if (run_len > RUN_TWO)
                        begin
                            emit(esc_tag, 1'b0, 1'b0);
                            emit(run_len - 8'd1, 1'b0, 1'b0);
                        end
                        emit(data, 1'b0, 1'b0);
                        run_byte = data;
                        run_len  = RUN_ONE;
                    end
                    else
                        run_len = run_len + 8'd1;

                    if (last)
                    begin
                        emit(esc_tag, 1'b0, 1'b0);
                        emit(8'd0, 1'b1, 1'b0);
                        reset_block();
                    end
                end
            end
            default: ;
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        enc_byte_t want;
        if (!rst_n)
        begin
            reset_block();
            enc_bytes_q.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            // Compare the result transaction with the oldest prediction
            if (m_tvalid && m_tready)
            begin
                if (enc_bytes_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("%0t: unexpected result data=%02h last=%b status=%b",
                                 $realtime, m_tdata, m_tlast, m_tuser[0]);
                end
                else
                begin
                    want = enc_bytes_q.pop_front();
                    if (m_tdata !== want.data || m_tlast !== want.last ||
                        m_tuser[0] !== want.status)
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_MAX)
                            $display("%0t: mismatch data %02h/%02h last %b/%b status %b/%b %s",
                                     $realtime, want.data, m_tdata, want.last, m_tlast,
                                     want.status, m_tuser[0], "(expected/actual)");
                    end
                end
            end

            // Predict results of the input transaction
            if (s_tvalid && s_tready)
                encode_step(s_tuser, s_tdata, s_tlast);

            pending = enc_bytes_q.size();
        end
    end

endmodule

>>> tb/tagged_rle_byte_encoder_core_tb.sv
// Testbench top for the tagged run-length byte encoder: drives byte blocks with
// random gaps, stalls the result side and reports the verdict.
// Depends on trle_pkg, tagged_rle_byte_encoder_core and trle_stream_checker.
`timescale 1ns / 1ps

module tagged_rle_byte_encoder_core_tb
    import trle_pkg::*;
();

    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam int         RAND_ITEMS  = 60;
    localparam int         HOLD_CYCLES = 400;
    localparam int         HOLD_AFTER  = 25;
    localparam int         DRAIN_CYCLES = 20;
    localparam real        LIMIT_NS    = 6000000.0;

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;   // [7:0] in_byte
    logic [1:0] s_tuser;   // [1:0] cmd
    logic       s_tlast;   // in_last
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;   // [7:0] out_byte
    logic [0:0] m_tuser;   // [0] out_status
    logic       m_tlast;   // out_last

    int         fail_count;
    int         pending;
    int         sent_count;
    bit         src_burst;
    bit         snk_burst;
    logic [7:0] blk[$];

    tagged_rle_byte_encoder_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    trle_stream_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Clock
    initial
        clk = 1'b0;
    always #6 clk = ~clk;

    // Run limit
    initial
    begin
        #(LIMIT_NS);
        $display("FAILURE");
        $finish;
    end

    // Offer one input transaction after a random gap, return at a falling edge
    task automatic send_item(input logic [1:0] cmd, input logic [7:0] data,
                             input logic last);
        int gap;
        gap = src_burst ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= data;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        sent_count++;
    endtask

    // Send the held block as one pass, last flag on its final byte
    task automatic send_pass(input logic [1:0] cmd);
        for (int i = 0; i < blk.size(); i++)
            send_item(cmd, blk[i], i == blk.size() - 1);
    endtask

    // Fill the block with runs of mostly short length
    task automatic make_runs(input int n);
        logic [7:0] v;
        int         run;
        int         sel;
        blk.delete();
        while (blk.size() < n)
        begin
            case ($urandom_range(0, 7))
                0:       v = 8'h00;
                1:       v = 8'hFF;
                2, 3:    v = 8'($urandom_range(0, 255));
                default: v = 8'h40 + 8'($urandom_range(0, 7));
            endcase
            sel = $urandom_range(0, 19);
            if (sel < 13)
                run = $urandom_range(1, 3);
            else if (sel < 19)
                run = $urandom_range(4, 12);
            else
                run = $urandom_range(13, 40);
            repeat (run)
                if (blk.size() < n)
                    blk.insert(blk.size(), v);
        end
    endtask

    function automatic int block_size();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
    endfunction

    // Result side: random stalls and one long hold-off
    initial
    begin : result_sink
        int gap;
        int taken;
        bit held;
        taken    = 0;
        held     = 0;
        m_tready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (!held && taken == HOLD_AFTER)
            begin
                gap  = HOLD_CYCLES;
                held = 1;
            end
            else
                gap = snk_burst ? 0 : $urandom_range(0, 12);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            taken++;
            if ($urandom_range(0, 39) == 0)
                snk_burst = !snk_burst;
            @(negedge clk);
        end
    end

    // Stimulus and verdict
    initial
    begin : stimulus
        int         goal;
        int         k;
        int         j;
        logic [7:0] v;
        logic [7:0] w;

        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = 8'd0;
        s_tuser    = CMD_COUNT;
        s_tlast    = 1'b0;
        sent_count = 0;
        src_burst  = 0;
        snk_burst  = 0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // Empty block closes with tag zero
        send_item(CMD_EMPTY, 8'hA5, 1'b1);
        // Encode without a count pass uses tag zero
        send_item(CMD_ENCODE, 8'h00, 1'b0);
        send_item(CMD_ENCODE, 8'h00, 1'b0);
        send_item(CMD_ENCODE, 8'hFF, 1'b1);
        // Single byte block
        send_item(CMD_COUNT, 8'h00, 1'b1);
        send_item(CMD_ENCODE, 8'h00, 1'b1);
        // Runs of three, two and one, last byte repeating
        blk = '{8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h80, 8'h80};
        send_pass(CMD_COUNT);
        send_pass(CMD_ENCODE);
        // Count bytes arriving during the encode pass
        send_item(CMD_COUNT, 8'h41, 1'b1);
        send_item(CMD_ENCODE, 8'h41, 1'b0);
        send_item(CMD_COUNT, 8'h42, 1'b0);
        send_item(CMD_ENCODE, 8'h42, 1'b1);
        // Unknown command
        send_item(CMD_UNUSED, 8'hFF, 1'b1);

        // Run longer than the cap
        v = 8'($urandom_range(0, 255));
        w = v ^ 8'h5A;
        blk.delete();
        repeat (256)
            blk.insert(blk.size(), v);
        blk.insert(blk.size(), w);
        send_item(CMD_COUNT, v, 1'b1);
        send_pass(CMD_ENCODE);

        // Tag 255, then every value marked so no tag remains
        blk.delete();
        for (int i = 0; i < 255; i++)
            blk.insert(blk.size(), i[7:0]);
        for (int i = 254; i > 0; i--)
        begin
            j      = $urandom_range(0, i);
            v      = blk[i];
            blk[i] = blk[j];
            blk[j] = v;
        end
        send_pass(CMD_COUNT);
        send_item(CMD_ENCODE, 8'h10, 1'b0);
        send_item(CMD_ENCODE, 8'h10, 1'b0);
        send_item(CMD_ENCODE, 8'h20, 1'b0);
        send_item(CMD_COUNT, 8'hFF, 1'b1);
        send_item(CMD_ENCODE, 8'h30, 1'b0);
        send_item(CMD_ENCODE, 8'h31, 1'b1);

        // Random blocks, mostly well formed
        goal = sent_count + RAND_ITEMS;
        while (sent_count < goal)
        begin
            if ($urandom_range(0, 4) == 0)
                src_burst = !src_burst;
            k = $urandom_range(0, 99);
            if (k < 55)
            begin
                make_runs(block_size());
                send_pass(CMD_COUNT);
                send_pass(CMD_ENCODE);
            end
            else if (k < 63)
            begin
                make_runs(block_size());
                send_pass(CMD_ENCODE);
            end
            else if (k < 71)
            begin
                // Broken encode pass: cut short and dropped, or altered content
                make_runs($urandom_range(2, 12));
                send_pass(CMD_COUNT);
                if ($urandom_range(0, 1) == 0)
                begin
                    j = $urandom_range(1, blk.size() - 1);
                    for (int i = 0; i < j; i++)
                        send_item(CMD_ENCODE, blk[i], 1'b0);
                    send_item(CMD_EMPTY, 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)));
                end
                else
                begin
                    j      = $urandom_range(0, blk.size() - 1);
                    blk[j] = 8'($urandom_range(0, 255));
                    send_pass(CMD_ENCODE);
                end
            end
            else if (k < 78)
                send_item(CMD_EMPTY, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            else if (k < 85)
                send_item(CMD_UNUSED, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            else if (k < 93)
            begin
                // Encode pass with count bytes mixed in
                make_runs(block_size());
                send_pass(CMD_COUNT);
                for (int i = 0; i < blk.size(); i++)
                begin
                    if ($urandom_range(0, 3) == 0)
                        send_item(CMD_COUNT, 8'($urandom_range(0, 255)),
                                  $urandom_range(0, 7) == 0);
                    send_item(CMD_ENCODE, blk[i], i == blk.size() - 1);
                end
            end
            else
            begin
                // Partial count pass dropped by an empty block
                make_runs($urandom_range(1, 8));
                for (int i = 0; i < blk.size(); i++)
                    send_item(CMD_COUNT, blk[i], 1'b0);
                send_item(CMD_EMPTY, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
        end
        s_tvalid <= 1'b0;

        // Drain outstanding results
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

>>> filelist.f
src/trle_pkg.sv
src/trle_front.sv
src/trle_fifo.sv
src/trle_back.sv
src/tagged_rle_byte_encoder_core.sv
tb/trle_stream_checker.sv
tb/tagged_rle_byte_encoder_core_tb.sv
